// ===== rtl/ccdtx_pkg.sv =====
// Shared types and constants for the bitwise-arbitration bus sender.
// No dependencies; imported by ccdtx_step and the top level.
`timescale 1ns / 1ps

package ccdtx_pkg;

   localparam int TICKS_PER_BIT = 4;
   localparam int QS_W          = $clog2(TICKS_PER_BIT);
   localparam int BIT_W         = 4;
   localparam int LAST_DATA_BIT = 8;
   localparam int END_BIT       = 10;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_TICK  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] tx_byte;
      logic       contend;
      logic       bus_level;
   } req_item_type;

   typedef struct packed {
      logic       line_out;
      logic       busy_res;
      logic       done_res;
      logic       won;
      logic [7:0] byte_seen;
   } rsp_item_type;

   typedef struct packed {
      logic [BIT_W-1:0] bit_index;
      logic [QS_W-1:0]  quarter_step;
      logic [7:0]       shift_byte;
      logic             sending;
      logic             running;
      logic             line_level;
   } tx_state_type;

   localparam tx_state_type STATE_RESET = '{
      bit_index:    '0,
      quarter_step: '0,
      shift_byte:   '0,
      sending:      1'b0,
      running:      1'b0,
      line_level:   1'b1
   };

endpackage

// ===== rtl/ccdtx_step.sv =====
// Per-item next-state and result logic of the arbitration sender.
// Depends on ccdtx_pkg.
`timescale 1ns / 1ps

module ccdtx_step import ccdtx_pkg::*; (
   input  req_item_type item,
   input  tx_state_type cur,
   output tx_state_type nxt,
   output rsp_item_type result
);

   logic [BIT_W-1:0] mask_sel;
   logic [7:0]       mask;
   logic             is_data;
   logic             tx_bit;
   logic             bus_low;
   logic             done;
   logic             won_now;
   logic [7:0]       seen;

   always_comb begin
      mask_sel = BIT_W'(LAST_DATA_BIT) - cur.bit_index;
      mask     = 8'(1) << mask_sel[2:0];
      is_data  = (cur.bit_index >= BIT_W'(1)) && (cur.bit_index <= BIT_W'(LAST_DATA_BIT));
      tx_bit   = |(cur.shift_byte & mask);
      bus_low  = !item.bus_level;
   end

   always_comb begin
      nxt     = cur;
      done    = 1'b0;
      won_now = 1'b0;
      seen    = 8'd0;
      unique case (item.mode)
         MODE_START: begin
            if (!cur.running) begin
               nxt.shift_byte   = item.tx_byte;
               nxt.sending      = item.contend;
               nxt.bit_index    = '0;
               nxt.quarter_step = '0;
               nxt.running      = 1'b1;
               nxt.line_level   = 1'b1;
            end
         end
         MODE_TICK: begin
            if (cur.running) begin
               if (cur.quarter_step == '0) begin
                  // drive tick
                  if (cur.sending) begin
                     if (cur.bit_index == '0) nxt.line_level = 1'b0;
                     else if (is_data)        nxt.line_level = tx_bit;
                     else                     nxt.line_level = 1'b1;
                  end
                  if (cur.bit_index >= BIT_W'(END_BIT)) begin
                     done             = 1'b1;
                     won_now          = cur.sending;
                     seen             = cur.shift_byte;
                     nxt.running      = 1'b0;
                     nxt.sending      = 1'b0;
                     nxt.bit_index    = '0;
                     nxt.quarter_step = '0;
                     nxt.line_level   = 1'b1;
                  end else begin
                     nxt.quarter_step = QS_W'(1);
                  end
               end else if (cur.quarter_step < QS_W'(TICKS_PER_BIT - 1)) begin
                  // sample tick: collision check, then rebuild if not sending
                  if (is_data) begin
                     if (cur.sending && tx_bit && bus_low) begin
                        nxt.sending    = 1'b0;
                        nxt.line_level = 1'b1;
                     end
                     if (!nxt.sending) begin
                        if (bus_low) nxt.shift_byte = cur.shift_byte & ~mask;
                        else         nxt.shift_byte = cur.shift_byte | mask;
                     end
                  end
                  nxt.quarter_step = cur.quarter_step + QS_W'(1);
               end else begin
                  nxt.quarter_step = '0;
                  nxt.bit_index    = cur.bit_index + BIT_W'(1);
               end
            end
         end
         default: nxt = cur;
      endcase
   end

   always_comb begin
      result.line_out  = nxt.line_level;
      result.busy_res  = nxt.running;
      result.done_res  = done;
      result.won       = won_now;
      result.byte_seen = seen;
   end

endmodule

// ===== rtl/ccd_bus_arbitration_tx.sv =====
// Top level of the bitwise-arbitration bus sender: input register, frame
// state, result register. Depends on ccdtx_pkg and ccdtx_step.
//
//   channel | ports                     | direction | one item is
//   --------+---------------------------+-----------+---------------------------
//   req     | req_valid / req_stall     | in        | a start or a quarter-bit tick
//   rsp     | rsp_valid / rsp_stall     | out       | status after that item
//
// Flow: one item per clock sustained while rsp is not stalled; an accepted
// item goes into the input register, then the state update writes the result
// register and sets rsp_valid. Reset clears frame state (line released) and
// both valid flags.
// A stall on rsp holds the result register; req stalls only when the input
// register is full and cannot move into the result register that cycle.
`timescale 1ns / 1ps

module ccd_bus_arbitration_tx import ccdtx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_tx_byte,
   input  logic       req_contend,
   input  logic       req_bus_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_out,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_won,
   output logic [7:0] rsp_byte_seen
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   tx_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         advance;   // input register moves into result register
   logic         req_take;

   // free result slot, or the one there leaves now
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ccdtx_step u_step (
      .item   (in_item_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .result (rsp_item_in)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      if (advance)                rsp_valid_in = 1'b1;
      else if (!rsp_stall)        rsp_valid_in = 1'b0;
      else                        rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode      <= mode_type'(req_mode);
         in_item_ff.tx_byte   <= req_tx_byte;
         in_item_ff.contend   <= req_contend;
         in_item_ff.bus_level <= req_bus_level;
      end
      if (advance) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_out  = rsp_item_ff.line_out;
   assign rsp_busy_res  = rsp_item_ff.busy_res;
   assign rsp_done_res  = rsp_item_ff.done_res;
   assign rsp_won       = rsp_item_ff.won;
   assign rsp_byte_seen = rsp_item_ff.byte_seen;

endmodule

// ===== rtl/ccdtx_checker.sv =====
// Port-level checks for ccd_bus_arbitration_tx, bound to the top level.
// Depends on the top-level port list only.
`timescale 1ns / 1ps

module ccdtx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_line_out,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic       rsp_won,
   input logic [7:0] rsp_byte_seen
);

   // frame end goes idle at once
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // won and byte_seen only carry meaning with done
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_won && (rsp_byte_seen == 8'd0))
      else $error("won/byte_seen nonzero without done");

   // idle side never pulls the line
   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_line_out)
      else $error("line driven low while idle");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_out)
         && $stable(rsp_busy_res) && $stable(rsp_done_res) && $stable(rsp_won)
         && $stable(rsp_byte_seen))
      else $error("stalled result changed");

endmodule

bind ccd_bus_arbitration_tx ccdtx_checker u_ccdtx_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_line_out  (rsp_line_out),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_won       (rsp_won),
   .rsp_byte_seen (rsp_byte_seen)
);

// ===== verif/ccd_bus_arbitration_tx_tb.sv =====
// Self-checking testbench for the bitwise-arbitration bus sender.
// Depends on ccdtx_pkg and ccd_bus_arbitration_tx; the frame status is predicted in place.
`timescale 1ns / 1ps

module ccd_bus_arbitration_tx_tb;
   import ccdtx_pkg::*;

   localparam int FRAME_TICKS    = END_BIT * TICKS_PER_BIT + 1;  // ticks from start to done
   localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before the run is declared hung
   localparam int DRAIN_CYCLES   = 8;      // margin for the last result to leave the result register
   localparam int CHUNKS         = 8;
   localparam int FRAMES_PER_CHUNK = 3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = MODE_TICK;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_contend = 1'b0;
   logic       req_bus_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_out;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_won;
   logic [7:0] rsp_byte_seen;

   req_item_type req_backlog[$];      // items waiting for the driver
   rsp_item_type expected_status[$];  // predicted status, oldest first
   req_item_type live_item;           // item currently on the req ports
   tx_state_type tx_shadow = STATE_RESET;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   ccd_bus_arbitration_tx uut (.*);

   always #2 clock = ~clock;

   // Shadow of the frame state machine. Returns the status the block shows
   // after taking one item; tx_shadow carries the state between items.
   function automatic rsp_item_type predict_status(req_item_type it);
      rsp_item_type r;
      logic [7:0]   mask;
      logic         bus_low;
      logic         data_bit;
      r = '0;
      bus_low  = !it.bus_level;
      data_bit = tx_shadow.bit_index >= 1 && tx_shadow.bit_index <= LAST_DATA_BIT;
      // bit 1 is the MSB, bit 8 the LSB
      mask     = 8'h80 >> (tx_shadow.bit_index - 4'd1);
      if (it.mode == MODE_START) begin
         // a start while a frame runs is dropped
         if (!tx_shadow.running) begin
            tx_shadow.shift_byte   = it.tx_byte;
            tx_shadow.sending      = it.contend;
            tx_shadow.bit_index    = '0;
            tx_shadow.quarter_step = '0;
            tx_shadow.running      = 1'b1;
            tx_shadow.line_level   = 1'b1;
         end
      end else if (tx_shadow.running) begin
         if (tx_shadow.quarter_step == 0) begin
            // first tick of a bit: drive the line
            if (tx_shadow.sending) begin
               if (tx_shadow.bit_index == 0)
                  tx_shadow.line_level = 1'b0;
               else if (data_bit)
                  tx_shadow.line_level = (tx_shadow.shift_byte & mask) != 0;
               else
                  tx_shadow.line_level = 1'b1;
            end
            if (tx_shadow.bit_index >= END_BIT) begin
               r.done_res  = 1'b1;
               r.won       = tx_shadow.sending;
               r.byte_seen = tx_shadow.shift_byte;
               tx_shadow   = STATE_RESET;
            end else begin
               tx_shadow.quarter_step = QS_W'(1);
            end
         end else if (tx_shadow.quarter_step < TICKS_PER_BIT - 1) begin
            // middle ticks: sample; start and stop bits are not checked
            if (data_bit) begin
               if (tx_shadow.sending && (tx_shadow.shift_byte & mask) != 0 && bus_low) begin
                  tx_shadow.sending    = 1'b0;
                  tx_shadow.line_level = 1'b1;
               end
               if (!tx_shadow.sending)
                  tx_shadow.shift_byte = bus_low ? tx_shadow.shift_byte & ~mask
                                                 : tx_shadow.shift_byte | mask;
            end
            tx_shadow.quarter_step = tx_shadow.quarter_step + 1'b1;
         end else begin
            tx_shadow.quarter_step = '0;
            tx_shadow.bit_index    = tx_shadow.bit_index + 1'b1;
         end
      end
      r.line_out = tx_shadow.line_level;
      r.busy_res = tx_shadow.running;
      return r;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic req_item_type tick_item(logic level);
      // byte and contend are don't-care on a tick; randomize them anyway
      return '{mode: MODE_TICK, tx_byte: 8'($urandom), contend: 1'($urandom),
               bus_level: level};
   endfunction

   // Queue one frame: a start, then the ticks with the bus level that an
   // open-collector bus shows when a rival sends 'rival' at the same time.
   // A rival of all ones means nobody else talks. noisy flips single samples
   // and drops stray starts in; tick_count below FRAME_TICKS cuts the frame short.
   task automatic queue_frame(logic [7:0] own, logic contend, logic [7:0] rival,
                              bit noisy, int tick_count, bit busy_start);
      logic level;
      logic own_bit;
      logic rival_bit;
      logic lost;
      int   bit_no;
      int   step;
      req_backlog.push_back('{mode: MODE_START, tx_byte: own, contend: contend,
                              bus_level: 1'($urandom)});
      lost = !contend;   // receive only: we never pull the line
      for (int k = 0; k < tick_count; k++) begin
         bit_no = k / TICKS_PER_BIT;
         step   = k % TICKS_PER_BIT;
         if (bit_no == 0) begin
            level = 1'b0;
         end else if (bit_no > LAST_DATA_BIT) begin
            level = 1'b1;
         end else begin
            own_bit   = own[LAST_DATA_BIT - bit_no];
            rival_bit = rival[LAST_DATA_BIT - bit_no];
            level     = lost ? rival_bit : own_bit & rival_bit;
            if (!lost && own_bit && !rival_bit && step == TICKS_PER_BIT - 1)
               lost = 1'b1;
         end
         if (noisy && $urandom_range(19) == 0)
            level = ~level;
         req_backlog.push_back(tick_item(level));
         if ((busy_start && k == 5 * TICKS_PER_BIT + 1) || (noisy && $urandom_range(29) == 0))
            req_backlog.push_back('{mode: MODE_START, tx_byte: 8'($urandom),
                                    contend: 1'($urandom), bus_level: 1'($urandom)});
      end
   endtask

   // Driver: presents backlog items, idles at random, holds the payload
   // while stalled. Expectations are formed at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_status.push_back(predict_status(live_item));
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               live_item = req_backlog.pop_front();
               req_valid     <= 1'b1;
               req_mode      <= live_item.mode;
               req_tx_byte   <= live_item.tx_byte;
               req_contend   <= live_item.contend;
               req_bus_level <= live_item.bus_level;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stall, compare each accepted status with the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $display("%0t: status item with nothing expected: %b %b %b %b %0h",
                        $time, rsp_line_out, rsp_busy_res, rsp_done_res, rsp_won,
                        rsp_byte_seen);
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("line_out", 8'(want.line_out), 8'(rsp_line_out));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               check_field("won", 8'(want.won), 8'(rsp_won));
               check_field("byte_seen", want.byte_seen, rsp_byte_seen);
            end
         end
         rsp_stall <= $urandom_range(99) < rsp_stall_pct;
      end
   end

   // Watchdog: cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("ccd_bus_arbitration_tx regression: fail");
      $finish;
   end

   initial begin
      int sender_idle[4];
      int receiver_stall[4];
      int kind;
      sender_idle    = '{0, 67, 0, 35};
      receiver_stall = '{0, 0, 67, 35};

      // Directed: ticks while idle, extreme bytes, a loss on the MSB,
      // receive only, a start while busy, split samples within one bit.
      req_backlog.push_back(tick_item(1'b0));
      req_backlog.push_back(tick_item(1'b1));
      queue_frame(8'hFF, 1'b1, 8'hFF, 1'b0, FRAME_TICKS, 1'b1);
      queue_frame(8'h00, 1'b1, 8'hFF, 1'b0, FRAME_TICKS, 1'b0);
      queue_frame(8'hFF, 1'b1, 8'h7F, 1'b0, FRAME_TICKS, 1'b0);
      queue_frame(8'hA5, 1'b0, 8'h3C, 1'b0, FRAME_TICKS, 1'b0);
      queue_frame(8'h5A, 1'b1, 8'h5A, 1'b1, FRAME_TICKS, 1'b0);
      req_backlog.push_back(tick_item(1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Random frames, phases rotating through the idling patterns.
      for (int c = 0; c < CHUNKS; c++) begin
         wait (req_backlog.size() == 0);
         send_idle_pct = sender_idle[c % 4];
         rsp_stall_pct = receiver_stall[c % 4];
         for (int f = 0; f < FRAMES_PER_CHUNK; f++) begin
            kind = $urandom_range(99);
            if (kind < 40)        // clean win
               queue_frame(8'($urandom), 1'b1, 8'hFF, 1'b0, FRAME_TICKS, 1'b0);
            else if (kind < 65)   // real contention, may lose
               queue_frame(8'($urandom), 1'b1, 8'($urandom), 1'b0, FRAME_TICKS, 1'b0);
            else if (kind < 80)   // listen only
               queue_frame(8'($urandom), 1'b0, 8'($urandom), 1'b0, FRAME_TICKS, 1'b0);
            else if (kind < 92)   // glitchy bus, stray starts
               queue_frame(8'($urandom), 1'($urandom), 8'($urandom), 1'b1, FRAME_TICKS,
                           1'($urandom));
            else                  // frame cut short; next start lands while busy
               queue_frame(8'($urandom), 1'($urandom), 8'($urandom), 1'b0,
                           $urandom_range(1, FRAME_TICKS - 1), 1'b0);
            repeat ($urandom_range(2))
               req_backlog.push_back(tick_item(1'($urandom)));
         end
      end

      while (req_backlog.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_status.size() != 0) begin
         $display("%0t: %0d status items never arrived", $time, expected_status.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("ccd_bus_arbitration_tx regression: pass");
      else
         $display("ccd_bus_arbitration_tx regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ccdtx_pkg.sv
rtl/ccdtx_step.sv
rtl/ccd_bus_arbitration_tx.sv
rtl/ccdtx_checker.sv
verif/ccd_bus_arbitration_tx_tb.sv
